[design/tcpg_pkg.sv]
// Shared constants, types and tables of the Taylor circle point generator.
package tcpg_pkg;

    localparam int TERM_LIMIT = 32;
    localparam int FRAC_BITS  = 30;

    localparam int DEG_W      = 12;
    localparam int MAXT_W     = 6;
    localparam int RADIUS_W   = 11;
    localparam int CENTER_W   = 12;
    localparam int COORD_W    = 14;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_TERMS = 2'd0,
        CFG_RADIUS    = 2'd1,
        CFG_CENTER_X  = 2'd2,
        CFG_CENTER_Y  = 2'd3
    } cfg_idx_t;

    localparam logic [MAXT_W-1:0]   MAXT_RST     = 6'd10;
    localparam logic [RADIUS_W-1:0] RADIUS_RST   = 11'd200;
    localparam logic [CENTER_W-1:0] CENTER_RST   = 12'd540;

    // pi in Q2.62, rounded to nearest at FRAC_BITS
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic [63:0] PI_FIX =
        (PI_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);

    localparam int PI_W    = FRAC_BITS + 2;
    localparam int MAG_W   = FRAC_BITS + 3;
    localparam int X2_W    = 2 * PI_W - FRAC_BITS;
    localparam int PROD_W  = MAG_W + X2_W;
    localparam int P_W     = PROD_W - FRAC_BITS;
    localparam int M_W     = P_W;
    localparam int M_LO_W  = (M_W + 1) / 2;
    localparam int M_HI_W  = M_W - M_LO_W;
    localparam int QQ_W    = P_W + M_W;
    localparam int X2_LO_W = (X2_W + 1) / 2;
    localparam int X2_HI_W = X2_W - X2_LO_W;
    localparam int SUM_W   = FRAC_BITS + 5;
    localparam int TERMS_W = $clog2(TERM_LIMIT + 1);
    localparam int N_W     = $clog2(TERM_LIMIT);
    localparam int D_W     = $clog2(4 * TERM_LIMIT * TERM_LIMIT);

    localparam int DEG_HALF_TURN = 180;
    localparam int QUOT_W   = $clog2(((1 << DEG_W) - 1) / DEG_HALF_TURN + 1);
    localparam int REM_W    = $clog2(DEG_HALF_TURN);
    // deg / 180 by reciprocal; the error never carries the quotient across a whole
    // number for 12-bit deg
    localparam int DIV_SHIFT = 20;
    localparam int DIV_MUL_W = 13;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((1 << DIV_SHIFT) + DEG_HALF_TURN - 1) / DEG_HALF_TURN);

    localparam int X0_W    = PI_W + QUOT_W;
    localparam int TRAW_W  = X0_W - FRAC_BITS;
    localparam int TERM_BASE = 15;

    localparam int V_W     = RADIUS_W + SUM_W + 2;

    typedef logic [PI_W-1:0] rad_tbl_t [DEG_HALF_TURN];

    // round-half-up(r * pi / 180) for the remainder degrees
    function automatic rad_tbl_t make_rad_tbl();
        rad_tbl_t    t;
        logic [63:0] v;
        for (int r = 0; r < DEG_HALF_TURN; r++)
        begin
            v = (64'(r) * PI_FIX + 64'(DEG_HALF_TURN / 2)) / DEG_HALF_TURN;
            t[r] = v[PI_W-1:0];
        end
        return t;
    endfunction

    localparam rad_tbl_t RAD_TBL = make_rad_tbl();

    typedef struct packed {
        logic                     valid;
        logic                     fin;
        logic                     x_neg;
        logic [TERMS_W-1:0]       terms;
        logic [X2_W-1:0]          x2;
        logic [MAG_W-1:0]         ts_mag;
        logic [MAG_W-1:0]         tc_mag;
        logic signed [SUM_W-1:0]  s_sum;
        logic signed [SUM_W-1:0]  c_sum;
    } term_t;

endpackage

[design/taylor_circle_point_generator_core.sv]
// Top level of the Taylor circle point generator: angle front end, series chain, point stage.
//
//  channel | signals                               | moves
//  --------+---------------------------------------+-----------------------------
//  in      | in_valid, in_stall, angle_step, ...   | one angle item
//  out     | out_valid, out_stall, point_x, ...    | one point item per angle item
//  cfg     | cfg_we, cfg_index, cfg_data           | register write, no wait
//
// One item enters per cycle while the output is not stalled.
// The series chain has one five-step stage per term but the last, each step at most one multiply.
// Reset clears all valid bits and loads the register defaults.
// A stalled output holding a valid point freezes the whole pipeline; in_stall follows at once.
module taylor_circle_point_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tcpg_pkg::DEG_W-1:0]          angle_step,
    input  logic                                final_point,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tcpg_pkg::COORD_W-1:0] point_x,
    output logic signed [tcpg_pkg::COORD_W-1:0] point_y,
    output logic                                final_out,
    input  logic                                cfg_we,
    input  logic [tcpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcpg_pkg::CFG_W-1:0]          cfg_data
);
    import tcpg_pkg::*;

    function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [V_W-1:0] v);
        logic [V_W-1:0]           mag;
        logic [V_W-FRAC_BITS-1:0] m;
        logic signed [COORD_W-1:0] r;
        mag = v[V_W-1] ? V_W'(-v) : V_W'(v);
        m   = mag[V_W-1:FRAC_BITS];
        if (!v[V_W-1])
            r = (m > (V_W-FRAC_BITS)'((1 << (COORD_W-1)) - 1)) ?
                COORD_W'((1 << (COORD_W-1)) - 1) : $signed(m[COORD_W-1:0]);
        else
            r = (m > (V_W-FRAC_BITS)'(1 << (COORD_W-1))) ?
                COORD_W'(1 << (COORD_W-1)) : -$signed(m[COORD_W-1:0]);
        return r;
    endfunction

    logic en;

    logic [MAXT_W-1:0]   max_terms_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [CENTER_W-1:0] center_x_reg, center_y_reg;

    // front end
    logic                  a_valid_reg, a_fin_reg;
    logic [DEG_W-1:0]      a_deg_reg;
    logic [QUOT_W-1:0]     a_quot_reg, a_quot_next;
    logic [DEG_W+DIV_MUL_W-1:0] quot_prod;

    logic                  b_valid_reg, b_fin_reg, b_odd_reg;
    logic [PI_W-1:0]       b_f_reg, b_f_next;
    logic [X0_W-1:0]       b_qpi_reg;
    logic [DEG_W-1:0]      rem_full;

    logic                  c_valid_reg, c_fin_reg, c_xneg_reg, c_xneg_next;
    logic [PI_W-1:0]       c_xmag_reg, c_xmag_next;
    logic [TERMS_W-1:0]    c_terms_reg, c_terms_next;
    logic [X0_W-1:0]       x0;
    logic [TRAW_W-1:0]     traw, tlim;

    term_t                 d_reg, d_next;
    logic [2*PI_W-1:0]     x2_full;

    term_t                 chain [TERM_LIMIT];

    // back end
    logic                  e0_valid_reg, e0_fin_reg;
    logic signed [SUM_W-1:0] e0_s_reg, e0_c_reg, e0_s_next, e0_c_next, l_ts, l_tc;
    logic                  l_use;

    logic                  e1_valid_reg, e1_fin_reg, e1_sneg_reg, e1_cneg_reg;
    logic [RADIUS_W+SUM_W-1:0] e1_sprod_reg, e1_cprod_reg;
    logic [SUM_W-1:0]      s_abs, c_abs;

    logic                  e2_valid_reg, e2_fin_reg;
    logic signed [V_W-1:0] e2_vx_reg, e2_vy_reg, vx_next, vy_next, px, py;

    logic                  out_valid_reg, final_out_reg;
    logic signed [COORD_W-1:0] point_x_reg, point_y_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_terms_reg <= MAXT_RST;
            radius_reg    <= RADIUS_RST;
            center_x_reg  <= CENTER_RST;
            center_y_reg  <= CENTER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_TERMS: max_terms_reg <= cfg_data[MAXT_W-1:0];
                CFG_RADIUS:    radius_reg    <= cfg_data[RADIUS_W-1:0];
                CFG_CENTER_X:  center_x_reg  <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:  center_y_reg  <= cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // degrees split into half turns and a remainder below 180
    always_comb
    begin
        quot_prod   = angle_step * DIV_MUL;
        a_quot_next = quot_prod[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
        rem_full    = a_deg_reg - DEG_W'(a_quot_reg * DEG_W'(DEG_HALF_TURN));
        b_f_next    = RAD_TBL[rem_full[REM_W-1:0]];
    end

    // term count from the unreduced angle; reduction into (-pi, pi]
    always_comb
    begin
        x0   = b_qpi_reg + X0_W'(b_f_reg);
        traw = TRAW_W'(TERM_BASE) + TRAW_W'(x0[X0_W-1:FRAC_BITS+1]);
        tlim = TRAW_W'(max_terms_reg);
        if (traw < tlim)
            tlim = traw;
        if (tlim > TRAW_W'(TERM_LIMIT))
            tlim = TRAW_W'(TERM_LIMIT);
        c_terms_next = tlim[TERMS_W-1:0];
        if (b_odd_reg && (b_f_reg != '0))
        begin
            c_xneg_next = 1'b1;
            c_xmag_next = PI_FIX[PI_W-1:0] - b_f_reg;
        end
        else if (b_odd_reg)
        begin
            c_xneg_next = 1'b0;
            c_xmag_next = PI_FIX[PI_W-1:0];
        end
        else
        begin
            c_xneg_next = 1'b0;
            c_xmag_next = b_f_reg;
        end
    end

    always_comb
    begin
        x2_full       = c_xmag_reg * c_xmag_reg;
        d_next.valid  = c_valid_reg;
        d_next.fin    = c_fin_reg;
        d_next.x_neg  = c_xneg_reg;
        d_next.terms  = c_terms_reg;
        d_next.x2     = x2_full[2*PI_W-1:FRAC_BITS];
        d_next.ts_mag = MAG_W'(c_xmag_reg);
        d_next.tc_mag = MAG_W'(1) << FRAC_BITS;
        d_next.s_sum  = '0;
        d_next.c_sum  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_reg       <= '0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_reg       <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_fin_reg   <= final_point;
            a_deg_reg   <= angle_step;
            a_quot_reg  <= a_quot_next;
            b_fin_reg   <= a_fin_reg;
            b_odd_reg   <= a_quot_reg[0];
            b_f_reg     <= b_f_next;
            b_qpi_reg   <= a_quot_reg * PI_FIX[PI_W-1:0];
            c_fin_reg   <= b_fin_reg;
            c_xneg_reg  <= c_xneg_next;
            c_xmag_reg  <= c_xmag_next;
            c_terms_reg <= c_terms_next;
        end
    end

    assign chain[0] = d_reg;

    for (genvar g = 0; g < TERM_LIMIT - 1; g++)
    begin : g_term
        // divisors of the next term
        localparam logic [63:0] NXT = 64'(g + 1);
        localparam logic [63:0] DS  = (2 * NXT) * (2 * NXT + 1);
        localparam logic [63:0] DC  = (2 * NXT - 1) * (2 * NXT);
        localparam logic [63:0] MS  = ((64'd1 << P_W) + DS - 64'd1) / DS;
        localparam logic [63:0] MC  = ((64'd1 << P_W) + DC - 64'd1) / DC;

        tcpg_term u_term (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .idx   (N_W'(g)),
            .ds    (DS[D_W-1:0]),
            .dc    (DC[D_W-1:0]),
            .ms    (MS[M_W-1:0]),
            .mc    (MC[M_W-1:0]),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    // last term only needs adding
    always_comb
    begin
        l_use     = TERMS_W'(TERM_LIMIT - 1) < chain[TERM_LIMIT-1].terms;
        l_ts      = $signed(SUM_W'(chain[TERM_LIMIT-1].ts_mag));
        l_tc      = $signed(SUM_W'(chain[TERM_LIMIT-1].tc_mag));
        e0_s_next = chain[TERM_LIMIT-1].s_sum;
        e0_c_next = chain[TERM_LIMIT-1].c_sum;
        if (l_use)
        begin
            e0_s_next = e0_s_next +
                ((chain[TERM_LIMIT-1].x_neg ^ N_W'(TERM_LIMIT - 1) % 2 == 1) ? -l_ts : l_ts);
            e0_c_next = e0_c_next + ((N_W'(TERM_LIMIT - 1) % 2 == 1) ? -l_tc : l_tc);
        end
        s_abs = e0_s_reg[SUM_W-1] ? SUM_W'(-e0_s_reg) : SUM_W'(e0_s_reg);
        c_abs = e0_c_reg[SUM_W-1] ? SUM_W'(-e0_c_reg) : SUM_W'(e0_c_reg);
        px    = $signed(V_W'(e1_cprod_reg));
        py    = $signed(V_W'(e1_sprod_reg));
        vx_next = (e1_cneg_reg ? -px : px) + $signed(V_W'(center_x_reg) << FRAC_BITS);
        vy_next = (e1_sneg_reg ? -py : py) + $signed(V_W'(center_y_reg) << FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e0_valid_reg  <= chain[TERM_LIMIT-1].valid;
            e1_valid_reg  <= e0_valid_reg;
            e2_valid_reg  <= e1_valid_reg;
            out_valid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_fin_reg    <= chain[TERM_LIMIT-1].fin;
            e0_s_reg      <= e0_s_next;
            e0_c_reg      <= e0_c_next;
            e1_fin_reg    <= e0_fin_reg;
            e1_sneg_reg   <= e0_s_reg[SUM_W-1];
            e1_cneg_reg   <= e0_c_reg[SUM_W-1];
            e1_sprod_reg  <= radius_reg * s_abs;
            e1_cprod_reg  <= radius_reg * c_abs;
            e2_fin_reg    <= e1_fin_reg;
            e2_vx_reg     <= vx_next;
            e2_vy_reg     <= vy_next;
            final_out_reg <= e2_fin_reg;
            point_x_reg   <= to_coord(e2_vx_reg);
            point_y_reg   <= to_coord(e2_vy_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign final_out = final_out_reg;

    a_terms_cap: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (c_terms_reg <= TERMS_W'(TERM_LIMIT)) &&
                        (c_terms_reg <= TERMS_W'(max_terms_reg)))
        else $error("term count above its cap");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> c_xmag_reg <= PI_FIX[PI_W-1:0])
        else $error("reduced angle outside [-pi, pi]");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(a_valid_reg) && $stable(d_reg) && $stable(e0_valid_reg))
        else $error("pipeline moved while output stalled");

endmodule

[design/tcpg_term.sv]
// One series stage: adds term n to both sums and derives term n+1 in five register steps.
module tcpg_term (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [tcpg_pkg::N_W-1:0] idx,
    input  logic [tcpg_pkg::D_W-1:0] ds,
    input  logic [tcpg_pkg::D_W-1:0] dc,
    input  logic [tcpg_pkg::M_W-1:0] ms,
    input  logic [tcpg_pkg::M_W-1:0] mc,
    input  tcpg_pkg::term_t          din,
    output tcpg_pkg::term_t          dout
);
    import tcpg_pkg::*;

    term_t s1_reg, s1_next, s2_reg, s3_reg, s4_reg, s5_reg, s5_next;

    logic [MAG_W+X2_LO_W-1:0] pps_lo_reg, ppc_lo_reg;
    logic [MAG_W+X2_HI_W-1:0] pps_hi_reg, ppc_hi_reg;
    logic [P_W-1:0]           ps2_reg, pc2_reg, ps2_next, pc2_next;
    logic [P_W-1:0]           ps3_reg, pc3_reg, ps4_reg, pc4_reg;
    logic [P_W+M_LO_W-1:0]    qqs_lo_reg, qqc_lo_reg;
    logic [P_W+M_HI_W-1:0]    qqs_hi_reg, qqc_hi_reg;
    logic [P_W-1:0]           q0s_reg, q0c_reg, q0s_next, q0c_next;

    logic                     use_term, neg_s, neg_c;
    logic signed [SUM_W-1:0]  ts_ext, tc_ext;
    logic [PROD_W-1:0]        full_s, full_c;
    logic [QQ_W-1:0]          qq_s, qq_c;
    logic [P_W+D_W-1:0]       chk_s, chk_c;
    logic [P_W-1:0]           qs, qc;

    // step 1: accumulate term n, start term * x^2
    always_comb
    begin
        use_term = TERMS_W'(idx) < din.terms;
        neg_s    = din.x_neg ^ idx[0];
        neg_c    = idx[0];
        ts_ext   = $signed(SUM_W'(din.ts_mag));
        tc_ext   = $signed(SUM_W'(din.tc_mag));
        s1_next  = din;
        if (use_term)
        begin
            s1_next.s_sum = din.s_sum + (neg_s ? -ts_ext : ts_ext);
            s1_next.c_sum = din.c_sum + (neg_c ? -tc_ext : tc_ext);
        end
    end

    // step 2: combine partial products, drop fraction bits
    always_comb
    begin
        full_s   = (PROD_W'(pps_hi_reg) << X2_LO_W) + PROD_W'(pps_lo_reg);
        full_c   = (PROD_W'(ppc_hi_reg) << X2_LO_W) + PROD_W'(ppc_lo_reg);
        ps2_next = full_s[PROD_W-1:FRAC_BITS];
        pc2_next = full_c[PROD_W-1:FRAC_BITS];
    end

    // step 4: quotient estimate, equal to the true quotient or one above
    always_comb
    begin
        qq_s     = (QQ_W'(qqs_hi_reg) << M_LO_W) + QQ_W'(qqs_lo_reg);
        qq_c     = (QQ_W'(qqc_hi_reg) << M_LO_W) + QQ_W'(qqc_lo_reg);
        q0s_next = qq_s[QQ_W-1:P_W];
        q0c_next = qq_c[QQ_W-1:P_W];
    end

    // step 5: correct the estimate
    always_comb
    begin
        chk_s   = q0s_reg * ds;
        chk_c   = q0c_reg * dc;
        qs      = (chk_s > (P_W+D_W)'(ps4_reg)) ? q0s_reg - P_W'(1) : q0s_reg;
        qc      = (chk_c > (P_W+D_W)'(pc4_reg)) ? q0c_reg - P_W'(1) : q0c_reg;
        s5_next = s4_reg;
        s5_next.ts_mag = qs[MAG_W-1:0];
        s5_next.tc_mag = qc[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            s5_reg <= s5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pps_lo_reg <= din.ts_mag * din.x2[X2_LO_W-1:0];
            pps_hi_reg <= din.ts_mag * din.x2[X2_W-1:X2_LO_W];
            ppc_lo_reg <= din.tc_mag * din.x2[X2_LO_W-1:0];
            ppc_hi_reg <= din.tc_mag * din.x2[X2_W-1:X2_LO_W];
            ps2_reg    <= ps2_next;
            pc2_reg    <= pc2_next;
            qqs_lo_reg <= ps2_reg * ms[M_LO_W-1:0];
            qqs_hi_reg <= ps2_reg * ms[M_W-1:M_LO_W];
            qqc_lo_reg <= pc2_reg * mc[M_LO_W-1:0];
            qqc_hi_reg <= pc2_reg * mc[M_W-1:M_LO_W];
            ps3_reg    <= ps2_reg;
            pc3_reg    <= pc2_reg;
            ps4_reg    <= ps3_reg;
            pc4_reg    <= pc3_reg;
            q0s_reg    <= q0s_next;
            q0c_reg    <= q0c_next;
        end
    end

    assign dout = s5_reg;

endmodule
